FILE: design/cmed_pkg.sv
// Shared types, byte constants and character-class helpers for the main-entry detector.
package cmed_pkg;

   localparam int BYTE_W = 8;
   localparam int KW_W   = 3;

   typedef enum logic [1:0] {
      MODE_CODE  = 2'd0,
      MODE_LINE  = 2'd1,
      MODE_BLOCK = 2'd2,
      MODE_QUOTE = 2'd3
   } lex_mode_type;

   // keyword match progress codes
   localparam logic [KW_W-1:0] KW_IDLE = 3'd0;
   localparam logic [KW_W-1:0] KW_M    = 3'd1;
   localparam logic [KW_W-1:0] KW_MA   = 3'd2;
   localparam logic [KW_W-1:0] KW_MAI  = 3'd3;
   localparam logic [KW_W-1:0] KW_MAIN = 3'd4;

   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
   localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_DQUOTE    = 8'h22;
   localparam logic [BYTE_W-1:0] CH_SQUOTE    = 8'h27;
   localparam logic [BYTE_W-1:0] CH_LPAREN    = 8'h28;
   localparam logic [BYTE_W-1:0] CH_STAR      = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [BYTE_W-1:0] CH_M         = 8'h6D;
   localparam logic [BYTE_W-1:0] CH_A         = 8'h61;
   localparam logic [BYTE_W-1:0] CH_I         = 8'h69;
   localparam logic [BYTE_W-1:0] CH_N         = 8'h6E;

   typedef struct packed {
      lex_mode_type    mode;
      logic            quote_is_single;
      logic            escape_pending;
      logic            slash_pending;
      logic            star_pending;
      logic            prev_was_ident;
      logic [KW_W-1:0] keyword_progress;
      logic            found_flag;
   } lex_state_type;

   localparam lex_state_type LEX_RESET_STATE = '{
      mode:             MODE_CODE,
      quote_is_single:  1'b0,
      escape_pending:   1'b0,
      slash_pending:    1'b0,
      star_pending:     1'b0,
      prev_was_ident:   1'b0,
      keyword_progress: KW_IDLE,
      found_flag:       1'b0
   };

   function automatic logic is_ident_byte(input logic [BYTE_W-1:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDERSCORE);
   endfunction

   function automatic logic is_space_byte(input logic [BYTE_W-1:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

endpackage

FILE: design/cmed_lexer.sv
// Next-state logic of the lexer: one source byte against the current scan state.
module cmed_lexer
   import cmed_pkg::*;
(
   input  lex_state_type     state_cur,
   input  logic [BYTE_W-1:0] text_byte,
   input  logic              first_byte,
   output lex_state_type     state_nxt
);

   lex_state_type   cur;
   logic [KW_W-1:0] kw_next;
   logic            kw_matched;
   logic            kw_hit;
   logic [BYTE_W-1:0] close_quote;
   logic            code_go;

   // start of file clears the scan before the byte is taken
   assign cur = first_byte ? LEX_RESET_STATE : state_cur;

   assign close_quote = cur.quote_is_single ? CH_SQUOTE : CH_DQUOTE;

   // keyword match on a code byte
   always_comb begin
      kw_next    = KW_IDLE;
      kw_matched = 1'b0;
      kw_hit     = 1'b0;
      case (cur.keyword_progress)
         KW_M: begin
            if (text_byte == CH_A) begin
               kw_next    = KW_MA;
               kw_matched = 1'b1;
            end
         end
         KW_MA: begin
            if (text_byte == CH_I) begin
               kw_next    = KW_MAI;
               kw_matched = 1'b1;
            end
         end
         KW_MAI: begin
            if (text_byte == CH_N) begin
               kw_next    = KW_MAIN;
               kw_matched = 1'b1;
            end
         end
         KW_MAIN: begin
            if (is_space_byte(text_byte)) begin
               kw_next    = KW_MAIN;
               kw_matched = 1'b1;
            end else if (text_byte == CH_LPAREN) begin
               kw_next    = KW_IDLE;
               kw_matched = 1'b1;
               kw_hit     = 1'b1;
            end
         end
         default: begin
            kw_matched = 1'b0;
         end
      endcase
      if (!kw_matched) begin
         kw_next = (text_byte == CH_M && !cur.prev_was_ident) ? KW_M : KW_IDLE;
      end
   end

   always_comb begin
      state_nxt = cur;
      code_go   = 1'b0;
      case (cur.mode)
         MODE_LINE: begin
            if (text_byte == CH_NEWLINE) begin
               state_nxt.mode = MODE_CODE;
            end
         end
         MODE_BLOCK: begin
            if (cur.star_pending && text_byte == CH_SLASH) begin
               state_nxt.mode         = MODE_CODE;
               state_nxt.star_pending = 1'b0;
            end else begin
               state_nxt.star_pending = (text_byte == CH_STAR);
            end
         end
         MODE_QUOTE: begin
            if (cur.escape_pending) begin
               state_nxt.escape_pending = 1'b0;
            end else if (text_byte == CH_BACKSLASH) begin
               state_nxt.escape_pending = 1'b1;
            end else if (text_byte == close_quote) begin
               state_nxt.mode = MODE_CODE;
            end
         end
         default: begin
            code_go = 1'b1;
            // resolve a pending slash: comment opener or plain code
            if (cur.slash_pending) begin
               state_nxt.slash_pending = 1'b0;
               if (text_byte == CH_SLASH) begin
                  state_nxt.mode = MODE_LINE;
                  code_go        = 1'b0;
               end else if (text_byte == CH_STAR) begin
                  state_nxt.mode         = MODE_BLOCK;
                  state_nxt.star_pending = 1'b0;
                  code_go                = 1'b0;
               end
            end
            if (code_go) begin
               state_nxt.keyword_progress = kw_next;
               if (kw_hit) begin
                  state_nxt.found_flag = 1'b1;
               end
               if (text_byte == CH_SLASH) begin
                  state_nxt.slash_pending = 1'b1;
               end else if (text_byte == CH_DQUOTE || text_byte == CH_SQUOTE) begin
                  state_nxt.mode            = MODE_QUOTE;
                  state_nxt.quote_is_single = (text_byte == CH_SQUOTE);
                  state_nxt.escape_pending  = 1'b0;
               end
            end
         end
      endcase
      state_nxt.prev_was_ident = is_ident_byte(text_byte);
   end

endmodule

FILE: design/c_main_entry_detector_core.sv
// Top level of the main-entry detector: stream ports, lexer state and result register.
//
// Usage: feed a C/C++ source file one byte per word on the req_ channel.
// req_tdata carries the byte, req_tuser marks the first byte of a file
// (clears all scan state before that byte is looked at) and req_tlast
// marks the final byte. Every accepted word yields exactly one rsp_ word:
// rsp_tdata[0] is the sticky "main(" verdict seen so far, rsp_tlast echoes
// req_tlast so the word carrying it holds the final verdict.
// rsp_tvalid rises in the cycle after a request is accepted.
// Throughput: one byte per cycle while the receiver keeps up; the lexer
// update is a single level of byte compares between the state register and itself.
// Reset (synchronous, active high) returns the lexer to ordinary code and
// empties the result register.
// When the receiver stalls, the result register holds its word and
// req_tready drops only while that register is full and not being drained;
// a word taken in the same cycle frees the slot for the next byte.
module c_main_entry_detector_core
   import cmed_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tuser,   // [0] first_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] entry_found, [7:1] zero
   output logic       rsp_tlast    // end_of_file
);

   lex_state_type state_ff;
   lex_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          found_ff;
   logic          found_in;
   logic          eof_ff;
   logic          eof_in;
   logic          req_take;

   // accept while the result slot is empty or draining this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   cmed_lexer u_lexer (
      .state_cur  (state_ff),
      .text_byte  (req_tdata),
      .first_byte (req_tuser),
      .state_nxt  (state_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      eof_in       = eof_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         found_in     = state_in.found_flag;
         eof_in       = req_tlast;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // lexer state advances only on an accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LEX_RESET_STATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   // result payload: hold until a new word replaces it
   always_ff @(posedge clock) begin
      found_ff <= found_in;
      eof_ff   <= eof_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, found_ff};
   assign rsp_tlast  = eof_ff;

endmodule

FILE: dv/c_main_entry_detector_core_tb.sv
// Testbench for the main-entry detector: byte-stream stimulus, scan predictor and verdict check.
module c_main_entry_detector_core_tb;
   import cmed_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Stop the run here if it has not finished by then.
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_WORDS = 1400;
   // Cycles to wait after the last verdict, for any stray extra word.
   localparam int DRAIN_CYCLES = 8;

   // One request word: a source byte plus its file markers.
   typedef struct packed {
      logic [7:0] text;
      logic       first;
      logic       last;
   } src_word_type;

   // One verdict word as the block must return it.
   typedef struct packed {
      logic found;
      logic eof;
   } verdict_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;    // [7:0] text_byte
   logic       req_tuser = 1'b0;  // [0] first_byte
   logic       req_tlast = 1'b0;  // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // [0] entry_found, [7:1] zero
   logic       rsp_tlast;         // end_of_file

   src_word_type pending_words[$];
   verdict_type  expected_verdicts[$];
   int           total_words;
   int           words_sent;
   int           errors;
   int           cycles;

   // Predictor state: the lexer as the block should hold it.
   lex_mode_type sc_mode;
   logic         sc_single;
   logic         sc_escape;
   logic         sc_slash;
   logic         sc_star;
   logic         sc_prev_ident;
   logic [2:0]   sc_kw;
   logic         sc_found;

   c_main_entry_detector_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Scan predictor
   // ---------------------------------------------------------------------

   function automatic logic word_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
             (c >= "a" && c <= "z") || c == CH_UNDERSCORE;
   endfunction

   // Space, tab, newline, vertical tab, form feed, carriage return.
   function automatic logic blank_char(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   task automatic clear_scan();
      sc_mode       = MODE_CODE;
      sc_single     = 1'b0;
      sc_escape     = 1'b0;
      sc_slash      = 1'b0;
      sc_star       = 1'b0;
      sc_prev_ident = 1'b0;
      sc_kw         = KW_IDLE;
      sc_found      = 1'b0;
   endtask

   // Advance the lexer by one byte; the first byte of a file starts from scratch.
   task automatic advance_scan(input logic [7:0] c, input logic restart);
      logic [2:0] nxt;
      logic       hit;
      logic       opener;
      if (restart) clear_scan();
      case (sc_mode)
         MODE_LINE: begin
            if (c == CH_NEWLINE) sc_mode = MODE_CODE;
         end
         MODE_BLOCK: begin
            if (sc_star && c == CH_SLASH) begin
               sc_mode = MODE_CODE;
               sc_star = 1'b0;
            end else begin
               sc_star = (c == CH_STAR);
            end
         end
         MODE_QUOTE: begin
            if (sc_escape) sc_escape = 1'b0;
            else if (c == CH_BACKSLASH) sc_escape = 1'b1;
            else if (c == (sc_single ? CH_SQUOTE : CH_DQUOTE)) sc_mode = MODE_CODE;
         end
         default: begin
            // A pending slash swallows the byte that turns it into a comment opener.
            opener = 1'b0;
            if (sc_slash) begin
               sc_slash = 1'b0;
               if (c == CH_SLASH) begin
                  sc_mode = MODE_LINE;
                  opener = 1'b1;
               end else if (c == CH_STAR) begin
                  sc_mode = MODE_BLOCK;
                  sc_star = 1'b0;
                  opener = 1'b1;
               end
            end
            if (!opener) begin
               nxt = KW_IDLE;
               hit = 1'b0;
               case (sc_kw)
                  KW_M: if (c == CH_A) begin
                     nxt = KW_MA;
                     hit = 1'b1;
                  end
                  KW_MA: if (c == CH_I) begin
                     nxt = KW_MAI;
                     hit = 1'b1;
                  end
                  KW_MAI: if (c == CH_N) begin
                     nxt = KW_MAIN;
                     hit = 1'b1;
                  end
                  KW_MAIN: begin
                     if (blank_char(c)) begin
                        nxt = KW_MAIN;
                        hit = 1'b1;
                     end else if (c == CH_LPAREN) begin
                        sc_found = 1'b1;
                        nxt = KW_IDLE;
                        hit = 1'b1;
                     end
                  end
                  default: ;
               endcase
               // A fresh 'm' only starts a match after a non-identifier byte.
               if (!hit) nxt = (c == CH_M && !sc_prev_ident) ? KW_M : KW_IDLE;
               sc_kw = nxt;
               if (c == CH_SLASH) begin
                  sc_slash = 1'b1;
               end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                  sc_mode   = MODE_QUOTE;
                  sc_single = (c == CH_SQUOTE);
                  sc_escape = 1'b0;
               end
            end
         end
      endcase
      // The identifier test looks at the raw byte, whatever mode it fell in.
      sc_prev_ident = word_char(c);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Queue one file's bytes; flags mark where the file opens and closes.
   task automatic queue_file(input logic [7:0] txt[$], input bit opens, input bit closes);
      src_word_type w;
      foreach (txt[i]) begin
         w.text  = txt[i];
         w.first = opens && (i == 0);
         w.last  = closes && (i == txt.size() - 1);
         pending_words = {pending_words, w};
      end
   endtask

   task automatic queue_text(input string s, input bit opens, input bit closes);
      logic [7:0] txt[$];
      for (int i = 0; i < s.len(); i++) txt = {txt, s[i]};
      queue_file(txt, opens, closes);
   endtask

   // Identifier byte, weighted toward the letters of the keyword.
   function automatic logic [7:0] ident_byte();
      case ($urandom_range(0, 5))
         0: return CH_M;
         1: return CH_A;
         2: return CH_I;
         3: return CH_N;
         4: return CH_UNDERSCORE;
         default: begin
            case ($urandom_range(0, 2))
               0: return 8'("0" + $urandom_range(0, 9));
               1: return 8'("A" + $urandom_range(0, 25));
               default: return 8'("a" + $urandom_range(0, 25));
            endcase
         end
      endcase
   endfunction

   function automatic logic [7:0] blank_byte();
      return $urandom_range(0, 2) == 0 ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4));
   endfunction

   // Build a file from lexical pieces: keywords, comments, literals and noise.
   task automatic add_random_file();
      logic [7:0] txt[$];
      int         pieces;
      int         n;
      pieces = $urandom_range(3, 16);
      for (int t = 0; t < pieces; t++) begin
         case ($urandom_range(0, 17))
            0, 1, 2: begin
               // keyword, sometimes glued to an identifier, often a full call
               if ($urandom_range(0, 3) == 0) txt = {txt, ident_byte()};
               txt = {txt, CH_M, CH_A, CH_I, CH_N};
               if ($urandom_range(0, 1)) begin
                  n = $urandom_range(0, 2);
                  repeat (n) txt = {txt, blank_byte()};
                  txt = {txt, CH_LPAREN};
               end
            end
            3: txt = {txt, CH_LPAREN};
            4, 5: begin
               n = $urandom_range(1, 3);
               repeat (n) txt = {txt, blank_byte()};
            end
            6: txt = {txt, CH_SLASH, CH_SLASH};
            7: txt = {txt, CH_SLASH, CH_STAR};
            8: txt = {txt, CH_STAR, CH_SLASH};
            9: txt = {txt, ($urandom_range(0, 1) ? CH_STAR : CH_SLASH)};
            10, 11: txt = {txt, ($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE)};
            12: txt = {txt, CH_BACKSLASH};
            13: txt = {txt, CH_NEWLINE};
            14, 15: begin
               n = $urandom_range(1, 4);
               repeat (n) txt = {txt, ident_byte()};
            end
            16: txt = {txt, 8'($urandom_range(0, 255))};
            default: txt = {txt, 8'($urandom_range(0, 127))};
         endcase
      end
      // Mostly well-framed files; a few run on or open mid-stream.
      queue_file(txt, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
   endtask

   // Loose bytes with random markers between files.
   task automatic add_noise();
      src_word_type w;
      int           n;
      n = $urandom_range(1, 5);
      repeat (n) begin
         w.text  = 8'($urandom_range(0, 255));
         w.first = 1'($urandom_range(0, 1));
         w.last  = 1'($urandom_range(0, 1));
         pending_words = {pending_words, w};
      end
   endtask

   // ---------------------------------------------------------------------
   // Pacing: sender idles 23%, receiver 62%, then swapped, then no idling.
   // ---------------------------------------------------------------------

   function automatic int pace_phase();
      return total_words == 0 ? 0 : (words_sent * 3) / total_words;
   endfunction

   function automatic bit sender_idles();
      case (pace_phase())
         0: return $urandom_range(0, 99) < 23;
         1: return $urandom_range(0, 99) < 62;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_idles();
      case (pace_phase())
         0: return $urandom_range(0, 99) < 62;
         1: return $urandom_range(0, 99) < 23;
         default: return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Driver: predict each accepted word, then present the next one.
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      src_word_type w;
      verdict_type  v;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_scan(req_tdata, req_tuser);
            v.found = sc_found;
            v.eof   = req_tlast;
            expected_verdicts = {expected_verdicts, v};
            words_sent++;
         end
         // Hold the word until it is taken; otherwise advance or idle.
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() != 0 && !sender_idles()) begin
               w = pending_words.pop_front();
               req_tdata  <= w.text;
               req_tuser  <= w.first;
               req_tlast  <= w.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each taken verdict against the oldest prediction.
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected verdict word tdata=%h tlast=%b",
                     $realtime, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = expected_verdicts.pop_front();
            // entry_found sits in bit 0; the upper bits must stay zero
            if (rsp_tdata !== {7'b0, want.found}) begin
               $display("%0t: entry_found mismatch expected=%h actual=%h",
                        $realtime, {7'b0, want.found}, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== want.eof) begin
               $display("%0t: end_of_file mismatch expected=%b actual=%b",
                        $realtime, want.eof, rsp_tlast);
               errors++;
            end
         end
      end
      rsp_tready <= !receiver_idles();
   end

   // Drop the run if it hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL c_main_entry_detector_core");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: fill the queue, release reset, drain, report.
   // ---------------------------------------------------------------------

   initial begin
      clear_scan();
      // call at file start with a vertical tab before the parenthesis
      queue_text("main\013(", 1'b1, 1'b1);
      // "/*/" stays open; the later "*/" closes; a lone slash ends the file
      queue_text("/*/*//", 1'b1, 1'b1);
      // bytes past the final byte continue the scan; a high byte is no letter
      queue_text("\377main(", 1'b0, 1'b1);
      // escaped quote keeps the literal open, so the call is hidden
      queue_text("'\\'main(", 1'b1, 1'b1);
      while (pending_words.size() < RANDOM_WORDS) begin
         if ($urandom_range(0, 9) == 0) add_noise();
         add_random_file();
      end
      total_words = pending_words.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_tvalid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && expected_verdicts.size() == 0) begin
         $display("PASS c_main_entry_detector_core");
      end else begin
         $display("FAIL c_main_entry_detector_core");
      end
      $finish;
   end

endmodule
